// File: hdl/csgl_pkg.sv
`default_nettype none

package csgl_pkg;

  // word kind carried in in_tuser
  localparam logic [1:0] FUNC_SEG_WR   = 2'd0;
  localparam logic [1:0] FUNC_GLYPH_WR = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP   = 2'd2;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 16;

  // in_tdata field offsets
  localparam int unsigned SEG_INDEX_LSB   = 0;
  localparam int unsigned SEG_START_LSB   = 8;
  localparam int unsigned SEG_END_LSB     = 24;
  localparam int unsigned SEG_DELTA_LSB   = 40;
  localparam int unsigned SEG_RANGE_LSB   = 56;
  localparam int unsigned GLYPH_WIDX_LSB  = 72;
  localparam int unsigned GLYPH_WORD_LSB  = 82;
  localparam int unsigned CHAR_CODE_LSB   = 98;

  localparam logic [15:0] CODE_LAST = 16'hFFFF;

  // one segment entry as held in the segment store
  typedef struct packed {
    logic [15:0] range_offset;
    logic [15:0] delta;
    logic [15:0] end_code;
    logic [15:0] start_code;
  } seg_entry_t;

endpackage

`default_nettype wire

// File: hdl/csgl_ram.sv
`default_nettype none

module csgl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/cmap_segment_glyph_lookup.sv
// lookup: segments scanned up to the covering one or the clamped segment count (one per cycle
//   through the segment store read port), then the start code check and, for a nonzero range offset, a glyph array read
// write words, unused kinds and characters above 0xFFFF go from acceptance straight to the
//   result handoff; one word in work at a time, in_tready low until the result moves into the
//   output register, which then waits for out_tready while the next word is taken
`default_nettype none

module cmap_segment_glyph_lookup #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned GLYPH_WORDS  = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [8:0]  cfg_wr_data,  // number of valid segments
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // seg_index, seg_start, seg_end, seg_delta, seg_range_offset, glyph_word_index,
  // glyph_word, char_code, one zero pad bit
  input  wire logic [csgl_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [1:0]  in_tuser,     // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [csgl_pkg::OUT_TDATA_W-1:0] out_tdata,  // glyph_id
  output logic             out_tuser     // found
);

  localparam int unsigned SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned GLY_AW = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SUM_W  = CNT_W + 18;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_HIT  = 6'b000100,
    S_GRD  = 6'b001000,
    S_GWT  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [8:0]             seg_count_r;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [15:0]            c_r, c_nxt;
  logic [CNT_W-1:0]       a_r, a_nxt;
  logic [CNT_W-1:0]       chk_r, chk_nxt;
  logic                   pend_r, pend_nxt;
  csgl_pkg::seg_entry_t   seg_r, seg_nxt;
  logic [CNT_W-1:0]       i_r, i_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [15:0]            res_glyph_r, res_glyph_nxt;
  logic                   res_found_r, res_found_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [15:0]            out_glyph_r, out_glyph_nxt;
  logic                   out_found_r, out_found_nxt;

  logic                   in_fire;
  logic [1:0]             func;
  csgl_pkg::seg_entry_t   seg_wdata, seg_rdata;
  logic                   seg_we, seg_re;
  logic [SEG_AW-1:0]      seg_waddr;
  logic                   g_we, g_re;
  logic [GLY_AW-1:0]      g_waddr, g_raddr;
  logic [15:0]            g_wdata, g_rdata;
  logic [7:0]             in_seg_index;
  logic [9:0]             in_glyph_widx;
  logic [20:0]            in_char;
  logic [31:0]            seg_idx32, glyph_idx32, count32;
  logic [SUM_W-1:0]       gidx;

  assign func          = in_tuser;
  assign in_fire       = in_tvalid && in_tready;
  assign in_tready     = (state_r == S_IDLE);
  assign in_seg_index  = in_tdata[csgl_pkg::SEG_INDEX_LSB +: 8];
  assign in_glyph_widx = in_tdata[csgl_pkg::GLYPH_WIDX_LSB +: 10];
  assign in_char       = in_tdata[csgl_pkg::CHAR_CODE_LSB +: 21];

  assign seg_wdata.start_code   = in_tdata[csgl_pkg::SEG_START_LSB +: 16];
  assign seg_wdata.end_code     = in_tdata[csgl_pkg::SEG_END_LSB +: 16];
  assign seg_wdata.delta        = in_tdata[csgl_pkg::SEG_DELTA_LSB +: 16];
  assign seg_wdata.range_offset = in_tdata[csgl_pkg::SEG_RANGE_LSB +: 16];
  assign g_wdata                = in_tdata[csgl_pkg::GLYPH_WORD_LSB +: 16];

  assign seg_idx32   = 32'(in_seg_index);
  assign glyph_idx32 = 32'(in_glyph_widx);
  assign seg_waddr   = seg_idx32[SEG_AW-1:0];
  assign g_waddr     = glyph_idx32[GLY_AW-1:0];
  assign seg_we      = in_fire && (func == csgl_pkg::FUNC_SEG_WR) &&
                       (seg_idx32 < 32'(MAX_SEGMENTS));
  assign g_we        = in_fire && (func == csgl_pkg::FUNC_GLYPH_WR) &&
                       (glyph_idx32 < 32'(GLYPH_WORDS));

  // count above the store depth acts as the depth
  assign count32 = (32'(seg_count_r) > 32'(MAX_SEGMENTS)) ? 32'(MAX_SEGMENTS)
                                                          : 32'(seg_count_r);

  // glyph array index relative to the array start
  assign gidx    = sum_r - SUM_W'(n_r);
  assign g_raddr = gidx[GLY_AW-1:0];

  csgl_ram #(
    .WIDTH ($bits(csgl_pkg::seg_entry_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .re    (seg_re),
    .raddr (a_r[SEG_AW-1:0]),
    .rdata (seg_rdata)
  );

  csgl_ram #(
    .WIDTH (16),
    .DEPTH (GLYPH_WORDS)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    c_nxt          = c_r;
    a_nxt          = a_r;
    chk_nxt        = chk_r;
    pend_nxt       = pend_r;
    seg_nxt        = seg_r;
    i_nxt          = i_r;
    sum_nxt        = sum_r;
    res_glyph_nxt  = res_glyph_r;
    res_found_nxt  = res_found_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_glyph_nxt  = out_glyph_r;
    out_found_nxt  = out_found_r;
    seg_re         = 1'b0;
    g_re           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_glyph_nxt = '0;
          res_found_nxt = 1'b0;
          state_nxt     = S_DONE;
          if (func == csgl_pkg::FUNC_LOOKUP && in_char[20:16] == '0) begin
            c_nxt     = in_char[15:0];
            n_nxt     = count32[CNT_W-1:0];
            a_nxt     = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read data of segment chk_r arrives while segment a_r is being read
        if (pend_r && (seg_rdata.end_code == csgl_pkg::CODE_LAST ||
                       seg_rdata.end_code >= c_r)) begin
          seg_nxt   = seg_rdata;
          i_nxt     = chk_r;
          state_nxt = S_HIT;
        end else if (a_r < n_r) begin
          seg_re   = 1'b1;
          chk_nxt  = a_r;
          a_nxt    = a_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_HIT: begin
        if (seg_r.start_code > c_r) begin
          state_nxt = S_DONE;
        end else begin
          res_found_nxt = 1'b1;
          if (seg_r.range_offset == '0) begin
            res_glyph_nxt = c_r + seg_r.delta;
            state_nxt     = S_DONE;
          end else begin
            sum_nxt   = SUM_W'(seg_r.range_offset[15:1]) + SUM_W'(c_r - seg_r.start_code)
                        + SUM_W'(i_r);
            state_nxt = S_GRD;
          end
        end
      end
      S_GRD: begin
        if (sum_r < SUM_W'(n_r) || gidx >= SUM_W'(GLYPH_WORDS)) begin
          state_nxt = S_DONE;
        end else begin
          g_re      = 1'b1;
          state_nxt = S_GWT;
        end
      end
      S_GWT: begin
        res_glyph_nxt = (g_rdata != '0) ? (g_rdata + seg_r.delta) : '0;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_glyph_nxt  = res_glyph_r;
          out_found_nxt  = res_found_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seg_count_r  <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        seg_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    c_r         <= c_nxt;
    a_r         <= a_nxt;
    chk_r       <= chk_nxt;
    seg_r       <= seg_nxt;
    i_r         <= i_nxt;
    sum_r       <= sum_nxt;
    res_glyph_r <= res_glyph_nxt;
    res_found_r <= res_found_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_glyph_r;
  assign out_tuser  = out_found_r;

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> a_r <= n_r)
    else $error("scan address past segment count");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && func != csgl_pkg::FUNC_LOOKUP |=> state_r == S_DONE)
    else $error("write word did not finish at once");

  a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
    g_re |-> (sum_r >= SUM_W'(n_r)) && (gidx < SUM_W'(GLYPH_WORDS)))
    else $error("glyph read outside array");

  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_tvalid_r || out_tready) |=>
      out_tvalid_r && out_glyph_r == $past(res_glyph_r) && state_r == S_IDLE)
    else $error("result not handed to output register");

endmodule

`default_nettype wire
